// ===== design/velocity_accel_clamp_friction_top_assert.svh =====
// Assertion macros used by the top-level design file.
`ifndef VELOCITY_ACCEL_CLAMP_FRICTION_TOP_ASSERT_SVH
`define VELOCITY_ACCEL_CLAMP_FRICTION_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VACF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("velocity block check failed");
`define VACF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("velocity block check failed");
`else
`define VACF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define VACF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/vacf_pkg.sv =====
package vacf_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned PROD_W = 2 * WORD_W;
  localparam int unsigned REG_W  = 31;
  localparam int unsigned DIR_W  = 16;
  localparam int unsigned DT_W   = 16;

  localparam logic [1:0] REG_MAX_SPEED  = 2'd0;
  localparam logic [1:0] REG_ACCEL_RATE = 2'd1;
  localparam logic [1:0] REG_DECEL_RATE = 2'd2;

  localparam logic [REG_W-1:0] MAX_SPEED_RESET = 31'd13107200;

  // Snap band around zero, 0.01 in Q16.16.
  localparam logic signed [32:0] EPS = 33'sd655;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PROD_W-1:0] prod_t;

  function automatic word_t abs32(logic signed [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [DIR_W-1:0] abs16(logic signed [15:0] v);
    abs16 = v[15] ? (~v + 16'd1) : v;
  endfunction

  // Adds a signed, saturated acceleration delta to a velocity axis.
  function automatic logic signed [31:0] accel_sum(logic signed [31:0] v, logic neg,
                                                   word_t m);
    logic signed [33:0] d;
    logic signed [33:0] s;
    if (!neg) begin
      d = (m > 32'h7fff_ffff) ? 34'sh7fff_ffff : $signed({2'b00, m});
    end else begin
      d = (m > 32'h8000_0000) ? -34'sh8000_0000 : -$signed({2'b00, m});
    end
    s = $signed({{2{v[31]}}, v}) + d;
    if (s > 34'sh7fff_ffff) begin
      accel_sum = 32'sh7fff_ffff;
    end else if (s < -34'sh8000_0000) begin
      accel_sum = 32'sh8000_0000;
    end else begin
      accel_sum = s[31:0];
    end
  endfunction

  function automatic logic signed [31:0] friction(logic signed [31:0] v,
                                                  logic [REG_W-1:0] d);
    logic signed [32:0] r;
    r = $signed({v[31], v});
    if (r > EPS) begin
      r = r - $signed({2'b00, d});
      if (r < EPS) r = '0;
    end else if (r < -EPS) begin
      r = r + $signed({2'b00, d});
      if (r > -EPS) r = '0;
    end
    friction = r[31:0];
  endfunction

  function automatic logic signed [31:0] disp_sat(logic neg, word_t m);
    if (!neg) begin
      disp_sat = (m > 32'h7fff_ffff) ? 32'sh7fff_ffff : m;
    end else begin
      disp_sat = (m > 32'h8000_0000) ? 32'sh8000_0000 : (~m + 32'd1);
    end
  endfunction

endpackage

// ===== design/vacf_mul.sv =====
module vacf_mul (
  input  logic                 clk,
  input  vacf_pkg::word_t      a,
  input  vacf_pkg::word_t      b,
  output vacf_pkg::prod_t      p_r
);
  import vacf_pkg::*;

  prod_t p_nxt;

  assign p_nxt = PROD_W'(a) * PROD_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

// ===== design/velocity_accel_clamp_friction_top.sv =====
// Tick: friction on both axes, then the displacement of each axis over time_step.
// Steer: acceleration on both axes, then a clamp to the speed limit when it is exceeded.
// One item at a time; the 32-step square root and two 31-step divides dominate,
// and one registered 32x32 multiplier serves every product in turn.
// rst_n (synchronous, active low) clears velocity, sequencer and output valid
// and restores the register defaults.
`include "velocity_accel_clamp_friction_top_assert.svh"
module velocity_accel_clamp_friction_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // dir_x [15:0], dir_y [31:16], time_step [47:32]
  input  logic [47:0]  in_tdata,
  // func [0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vel_x [31:0], vel_y [63:32], disp_x [95:64], disp_y [127:96]
  output logic [127:0] out_tdata
);
  import vacf_pkg::*;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_AC_DT    = 5'd1;
  localparam logic [4:0] ST_AC_RATE  = 5'd2;
  localparam logic [4:0] ST_AC_ADD   = 5'd3;
  localparam logic [4:0] ST_SQ_X     = 5'd4;
  localparam logic [4:0] ST_SQ_Y     = 5'd5;
  localparam logic [4:0] ST_SQ_SUM   = 5'd6;
  localparam logic [4:0] ST_SQRT     = 5'd7;
  localparam logic [4:0] ST_CMP      = 5'd8;
  localparam logic [4:0] ST_CL_MUL   = 5'd9;
  localparam logic [4:0] ST_CL_LOAD  = 5'd10;
  localparam logic [4:0] ST_CL_DIV   = 5'd11;
  localparam logic [4:0] ST_CL_WR    = 5'd12;
  localparam logic [4:0] ST_TF_MUL   = 5'd13;
  localparam logic [4:0] ST_TF_APPLY = 5'd14;
  localparam logic [4:0] ST_TD_X     = 5'd15;
  localparam logic [4:0] ST_TD_Y     = 5'd16;
  localparam logic [4:0] ST_TD_END   = 5'd17;
  localparam logic [4:0] ST_DONE     = 5'd18;

  logic [4:0]          state_r, state_nxt;
  logic [REG_W-1:0]    max_speed_r, accel_r, decel_r;
  logic signed [31:0]  vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [31:0]  px_r, px_nxt, py_r, py_nxt;
  logic signed [15:0]  dir_x_r, dir_y_r;
  logic [DT_W-1:0]     dt_r;
  logic                axis_r, axis_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  prod_t               sum_r, sum_nxt;
  prod_t               root_r, root_nxt;
  prod_t               bit_r, bit_nxt;
  word_t               rem_r, rem_nxt;
  logic [30:0]         dvd_r, dvd_nxt;
  logic [30:0]         q_r, q_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [127:0]        out_data_r, out_data_nxt;

  word_t               mul_a, mul_b;
  prod_t               prod_r;
  logic signed [31:0]  v_sel;
  logic signed [15:0]  dir_sel;
  prod_t               sq_try;
  logic [32:0]         div_rem2;
  logic                div_ge;
  word_t               mag;
  logic                accept;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign v_sel     = axis_r ? vy_r : vx_r;
  assign dir_sel   = axis_r ? dir_y_r : dir_x_r;
  assign mag       = root_r[31:0];
  assign sq_try    = root_r + bit_r;
  assign div_rem2  = {rem_r, dvd_r[30]};
  assign div_ge    = div_rem2 >= {1'b0, mag};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_AC_DT: begin
        mul_a = WORD_W'(abs16(dir_sel));
        mul_b = WORD_W'(dt_r);
      end
      ST_AC_RATE: begin
        mul_a = WORD_W'(accel_r);
        mul_b = prod_r[31:0];
      end
      ST_SQ_X: begin
        mul_a = abs32(vx_r);
        mul_b = abs32(vx_r);
      end
      ST_SQ_Y: begin
        mul_a = abs32(vy_r);
        mul_b = abs32(vy_r);
      end
      ST_CL_MUL: begin
        mul_a = abs32(v_sel);
        mul_b = WORD_W'(max_speed_r);
      end
      ST_TF_MUL: begin
        mul_a = WORD_W'(decel_r);
        mul_b = WORD_W'(dt_r);
      end
      ST_TD_X: begin
        mul_a = abs32(vx_r);
        mul_b = WORD_W'(dt_r);
      end
      ST_TD_Y: begin
        mul_a = abs32(vy_r);
        mul_b = WORD_W'(dt_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  vacf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  always_comb begin
    state_nxt     = state_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    axis_nxt      = axis_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          axis_nxt  = 1'b0;
          px_nxt    = '0;
          py_nxt    = '0;
          state_nxt = in_tuser ? ST_TF_MUL : ST_AC_DT;
        end
      end
      ST_AC_DT:   state_nxt = ST_AC_RATE;
      ST_AC_RATE: state_nxt = ST_AC_ADD;
      ST_AC_ADD: begin
        // The product is below 2^62, so bits 61:30 hold the shifted magnitude.
        if (!axis_r) begin
          vx_nxt    = accel_sum(vx_r, dir_sel[15], prod_r[61:30]);
          axis_nxt  = 1'b1;
          state_nxt = ST_AC_DT;
        end else begin
          vy_nxt    = accel_sum(vy_r, dir_sel[15], prod_r[61:30]);
          axis_nxt  = 1'b0;
          state_nxt = ST_SQ_X;
        end
      end
      ST_SQ_X: state_nxt = ST_SQ_Y;
      ST_SQ_Y: begin
        sum_nxt   = prod_r;
        state_nxt = ST_SQ_SUM;
      end
      ST_SQ_SUM: begin
        sum_nxt   = sum_r + prod_r;
        root_nxt  = '0;
        bit_nxt   = prod_t'(1) << (PROD_W - 2);
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (sum_r >= sq_try) begin
          sum_nxt  = sum_r - sq_try;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        axis_nxt  = 1'b0;
        state_nxt = (mag > WORD_W'(max_speed_r)) ? ST_CL_MUL : ST_DONE;
      end
      ST_CL_MUL: state_nxt = ST_CL_LOAD;
      ST_CL_LOAD: begin
        // The quotient fits in 31 bits, so the top of the dividend is below mag.
        rem_nxt   = prod_r[62:31];
        dvd_nxt   = prod_r[30:0];
        q_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = ST_CL_DIV;
      end
      ST_CL_DIV: begin
        rem_nxt = div_ge ? 32'(div_rem2 - {1'b0, mag}) : div_rem2[31:0];
        dvd_nxt = {dvd_r[29:0], 1'b0};
        q_nxt   = {q_r[29:0], div_ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd30) state_nxt = ST_CL_WR;
      end
      ST_CL_WR: begin
        if (!axis_r) begin
          vx_nxt    = vx_r[31] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
          axis_nxt  = 1'b1;
          state_nxt = ST_CL_MUL;
        end else begin
          vy_nxt    = vy_r[31] ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
          axis_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_TF_MUL: state_nxt = ST_TF_APPLY;
      ST_TF_APPLY: begin
        vx_nxt    = friction(vx_r, prod_r[46:16]);
        vy_nxt    = friction(vy_r, prod_r[46:16]);
        state_nxt = ST_TD_X;
      end
      ST_TD_X: state_nxt = ST_TD_Y;
      ST_TD_Y: begin
        px_nxt    = disp_sat(vx_r[31], prod_r[47:16]);
        state_nxt = ST_TD_END;
      end
      ST_TD_END: begin
        py_nxt    = disp_sat(vy_r[31], prod_r[47:16]);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {py_r, px_r, vy_r, vx_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vx_r        <= '0;
      vy_r        <= '0;
      axis_r      <= 1'b0;
      cnt_r       <= '0;
      max_speed_r <= MAX_SPEED_RESET;
      accel_r     <= '0;
      decel_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vx_r        <= vx_nxt;
      vy_r        <= vy_nxt;
      axis_r      <= axis_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MAX_SPEED:  max_speed_r <= cfg_wdata;
          REG_ACCEL_RATE: accel_r     <= cfg_wdata;
          REG_DECEL_RATE: decel_r     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    sum_r      <= sum_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
    if (accept) begin
      dir_x_r <= in_tdata[15:0];
      dir_y_r <= in_tdata[31:16];
      dt_r    <= in_tdata[47:32];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `VACF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, !in_tready)
  `VACF_ASSERT_IMP(a_result_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_DONE)
  `VACF_ASSERT_IMP(a_root_fits_word, clk, rst_n, state_r == ST_CMP, root_r[63:32] == 32'd0)

endmodule
